FILE: hdl/gcr_telemetry_edge_decoder_defines.svh
// assertion macros for the telemetry edge decoder
`ifndef GCR_TELEMETRY_EDGE_DECODER_DEFINES_SVH
`define GCR_TELEMETRY_EDGE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// clocked check, masked while reset is held
`define GCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define GCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`else

`define GCR_ASSERT(lbl, prop, msg)
`define GCR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: hdl/gcr_ted_pkg.sv
package gcr_ted_pkg;

    // width of the wrapping capture timer
    localparam int TS_BITS = 32;

    localparam int WORD_BITS = 21;
    localparam logic [4:0] BITS_FULL = 5'd21;
    localparam logic [4:0] BITS_OVERFLOW = 5'd22;

    // round-to-nearest run: (gap + 8) / 16
    localparam int RUN_ROUND = 8;
    localparam int RUN_SHIFT = 4;

    localparam logic [3:0] CHECK_NIBBLE = 4'hf;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_LENGTH   = 2'd1,
        ST_CHECKSUM = 2'd2
    } t_frame_status;

    // gcr 5b -> nibble, codes outside the set give 0
    function automatic logic [3:0] gcr_nibble(input logic [4:0] sym);
        logic [3:0] nib;
        case (sym)
            5'h09:   nib = 4'h9;
            5'h0a:   nib = 4'ha;
            5'h0b:   nib = 4'hb;
            5'h0d:   nib = 4'hd;
            5'h0e:   nib = 4'he;
            5'h0f:   nib = 4'hf;
            5'h12:   nib = 4'h2;
            5'h13:   nib = 4'h3;
            5'h15:   nib = 4'h5;
            5'h16:   nib = 4'h6;
            5'h17:   nib = 4'h7;
            5'h1a:   nib = 4'h8;
            5'h1b:   nib = 4'h1;
            5'h1d:   nib = 4'h4;
            5'h1e:   nib = 4'hc;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

endpackage

FILE: hdl/gcr_telemetry_edge_decoder.sv
// an input transaction reaches the result through the input register, then the result register
// throughput: one edge per cycle unless a frame end stalls; only an edge with tlast set produces a result transaction
// the frame state loop (gap, run, word shift) is combinational, so edges run back to back
// reset: i_rst_n synchronous active low; clears both valid flags and all frame state,
//        the decoder then waits for the first edge of a frame
`include "gcr_telemetry_edge_decoder_defines.svh"

module gcr_telemetry_edge_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // edge input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] edge_time
    input  logic        i_s_axis_tlast,   // last_edge
    // decoded frame stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [11:0] payload, [13:12] frame_status, [15:14] zero
);

    localparam int TS = gcr_ted_pkg::TS_BITS;
    localparam int LW = TS + 1 - gcr_ted_pkg::RUN_SHIFT;   // rounded run length width

    // input register
    logic          r_in_valid;
    logic [31:0]   r_in_time;
    logic          r_in_last;

    // frame state
    logic [TS-1:0] r_prev, n_prev;
    logic [20:0]   r_word, n_word;
    logic [4:0]    r_bits, n_bits;
    logic          r_err, n_err;
    logic          r_first, n_first;

    // result register
    logic          r_out_valid;
    logic [11:0]   r_out_payload;
    gcr_ted_pkg::t_frame_status r_out_status;

    logic          s_fire;

    // gap and run
    logic [TS-1:0] now;
    logic [TS-1:0] gap;
    logic [TS:0]   gap_rnd;
    logic [LW-1:0] run_len;
    logic [4:0]    room;
    logic          gap_bad;
    logic          run_over;
    logic          full_before;
    logic [4:0]    fin_len;

    // decode
    logic [15:0]   dec;
    logic [3:0]    cs;
    logic [11:0]   res_payload;
    gcr_ted_pkg::t_frame_status res_status;

    // the stage moves unless it holds a frame end and the result slot is blocked
    assign s_fire          = r_in_valid & (~r_in_last | ~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_valid | s_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_time <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // gap arithmetic wraps at the timer width, top bit set means negative
    assign now      = r_in_time[TS-1:0];
    assign gap      = now - r_prev;
    assign gap_rnd  = {1'b0, gap} + (TS+1)'(gcr_ted_pkg::RUN_ROUND);
    assign run_len  = gap_rnd[TS:gcr_ted_pkg::RUN_SHIFT];
    assign gap_bad  = gap[TS-1] | (gap < TS'(gcr_ted_pkg::RUN_ROUND));
    assign room     = gcr_ted_pkg::BITS_FULL - r_bits;
    assign run_over = run_len > LW'(room);

    always_comb begin
        n_prev      = r_prev;
        n_word      = r_word;
        n_bits      = r_bits;
        n_err       = r_err;
        n_first     = r_first;
        full_before = 1'b0;
        fin_len     = '0;
        dec         = '0;
        cs          = '0;
        res_payload = '0;
        res_status  = gcr_ted_pkg::ST_VALID;

        if (s_fire) begin
            n_prev = now;
            if (r_first) begin
                // first edge only stamps the time
                n_first = 1'b0;
            end else begin
                full_before = r_bits >= gcr_ted_pkg::BITS_FULL;
                if (!full_before) begin
                    if (gap_bad) begin
                        n_err = 1'b1;
                    end else if (!r_err) begin
                        if (run_over) begin
                            n_bits = gcr_ted_pkg::BITS_OVERFLOW;
                        end else begin
                            n_word = (r_word << run_len[4:0])
                                   | (21'd1 << (run_len[4:0] - 5'd1));
                            n_bits = r_bits + run_len[4:0];
                        end
                    end
                end
            end

            if (r_in_last) begin
                // close the word with one final run
                if (!full_before && !n_err) begin
                    if (n_bits >= gcr_ted_pkg::BITS_FULL) begin
                        n_err = 1'b1;
                    end else begin
                        fin_len = gcr_ted_pkg::BITS_FULL - n_bits;
                        n_word  = (n_word << fin_len) | (21'd1 << (fin_len - 5'd1));
                        n_bits  = gcr_ted_pkg::BITS_FULL;
                    end
                end

                dec = {gcr_ted_pkg::gcr_nibble(n_word[19:15]),
                       gcr_ted_pkg::gcr_nibble(n_word[14:10]),
                       gcr_ted_pkg::gcr_nibble(n_word[9:5]),
                       gcr_ted_pkg::gcr_nibble(n_word[4:0])};
                cs  = dec[15:12] ^ dec[11:8] ^ dec[7:4] ^ dec[3:0];

                if (n_err || n_bits != gcr_ted_pkg::BITS_FULL) begin
                    res_status = gcr_ted_pkg::ST_LENGTH;
                end else if (cs != gcr_ted_pkg::CHECK_NIBBLE) begin
                    res_status = gcr_ted_pkg::ST_CHECKSUM;
                end else begin
                    res_payload = dec[15:4];
                end

                // back to the idle frame state
                n_prev  = '0;
                n_word  = '0;
                n_bits  = '0;
                n_err   = 1'b0;
                n_first = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_word  <= '0;
            r_bits  <= '0;
            r_err   <= 1'b0;
            r_first <= 1'b1;
        end else begin
            r_prev  <= n_prev;
            r_word  <= n_word;
            r_bits  <= n_bits;
            r_err   <= n_err;
            r_first <= n_first;
        end
    end

    // result register, refilled in the same cycle it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (s_fire && r_in_last) begin
            r_out_payload <= res_payload;
            r_out_status  <= res_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_status, r_out_payload};

    `GCR_ASSERT(a_pay_zero_on_fail, r_out_valid && r_out_status != gcr_ted_pkg::ST_VALID |-> r_out_payload == 12'd0, "payload not zero on failed frame")
    `GCR_ASSERT(a_bits_range, r_bits <= gcr_ted_pkg::BITS_OVERFLOW, "bit count beyond overflow mark")
    `GCR_ASSERT(a_frame_clears, s_fire && r_in_last |=> r_first && r_bits == 5'd0 && !r_err, "frame state not cleared after frame end")
    `GCR_ASSERT(a_first_empty, r_first |-> r_bits == 5'd0 && r_word == 21'd0 && !r_err, "pending first edge with stale frame state")

endmodule
